>>> hdl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Register indexes, result codes and the constants of the integer
// compensation scheme.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B1_B2        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MC_MD        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLING = 3'd5;

  localparam logic [31:0] CAL_RESET = 32'hFFFF_FFFF;
  localparam logic [1:0]  OSS_RESET = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_PRES = 1'b1;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic [31:0] P_COEF_A  = 32'd3038;
  localparam logic [31:0] P_COEF_B  = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_COEF_C  = 32'd3791;

  localparam logic signed [31:0] TEMP_MAX = 32'sd32767;
  localparam logic signed [31:0] TEMP_MIN = -32'sd32768;
  localparam logic signed [31:0] PRES_MAX = 32'sd262143;

endpackage

`default_nettype wire

>>> hdl/barometric_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Turns raw temperature and pressure readings into compensated values.
// ----------------------------------------------------------------------------
// One reading is handled at a time. All products go through one bit-serial
// shift-and-add multiplier and all quotients through one restoring divider,
// steered by a step sequencer. A temperature reading takes one multiply and
// one divide; a pressure reading takes ten multiplies and one divide. A
// finished result sits in the output register, so the next reading can be
// accepted while it waits. A pressure reading uses the B5 term kept from the
// last temperature reading with a valid divisor (zero after reset).
`default_nettype none

module barometric_sensor_compensation_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic [18:0]                  raw_sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              result_kind_o,
  output logic signed [15:0]                temperature_tenths_o,
  output logic [17:0]                       pressure_pa_o,
  output logic [1:0]                        status_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [3:0] ST_T_MUL = 4'd0;
  localparam logic [3:0] ST_T_DIV = 4'd1;
  localparam logic [3:0] ST_P_SQ  = 4'd2;
  localparam logic [3:0] ST_P_X1  = 4'd3;
  localparam logic [3:0] ST_P_X2  = 4'd4;
  localparam logic [3:0] ST_P_X3  = 4'd5;
  localparam logic [3:0] ST_P_X4  = 4'd6;
  localparam logic [3:0] ST_P_B4  = 4'd7;
  localparam logic [3:0] ST_P_B7  = 4'd8;
  localparam logic [3:0] ST_P_DIV = 4'd9;
  localparam logic [3:0] ST_P_SQ2 = 4'd10;
  localparam logic [3:0] ST_P_K1  = 4'd11;
  localparam logic [3:0] ST_P_K2  = 4'd12;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

  function automatic logic [39:0] sx40(input logic [31:0] v);
    sx40 = {{8{v[31]}}, v};
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] h);
    sx16 = {{16{h[15]}}, h};
  endfunction

  // Configuration
  logic [31:0] cal_a12_q, cal_a34_q, cal_a56_q, cal_b12_q, cal_mcd_q;
  logic [1:0]  oss_q;

  // Sequencer and datapath
  logic [2:0]  state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        op_q, op_d;
  logic [18:0] raw_q, raw_d;
  logic [31:0] tt_q, tt_d;
  logic [31:0] sq_q, sq_d, xa_q, xa_d, b3_q, b3_d, b4_q, b4_d, b7_q, b7_d, p_q, p_d;
  logic [39:0] acc_q, acc_d, ma_q, ma_d;
  logic [31:0] mb_q, mb_d;
  logic [31:0] rem_q, rem_d, dvd_q, dvd_d, dvs_q, dvs_d;
  logic        neg_q, neg_d;

  // Finished result and output register
  logic        fk_q, fk_d;
  logic [15:0] ft_q, ft_d;
  logic [17:0] fp_q, fp_d;
  logic [1:0]  fs_q, fs_d;
  logic        ov_q, ov_d;
  logic        ok_q, ok_d;
  logic [15:0] ot_q, ot_d;
  logic [17:0] op_pa_q, op_pa_d;
  logic [1:0]  os_q, os_d;

  // Calibration fields
  logic [31:0] ac1, ac2, ac3, ac4, b1, b2, mdx;
  logic [15:0] ac5, ac6, mc;
  logic [31:0] b6, prod;

  assign ac1  = sx16(cal_a12_q[31:16]);
  assign ac2  = sx16(cal_a12_q[15:0]);
  assign ac3  = sx16(cal_a34_q[31:16]);
  assign ac4  = {16'd0, cal_a34_q[15:0]};
  assign ac5  = cal_a56_q[31:16];
  assign ac6  = cal_a56_q[15:0];
  assign b1   = sx16(cal_b12_q[31:16]);
  assign b2   = sx16(cal_b12_q[15:0]);
  assign mc   = cal_mcd_q[31:16];
  assign mdx  = sx16(cal_mcd_q[15:0]);
  assign b6   = tt_q - bsc_pkg::B6_OFFSET;
  assign prod = acc_q[31:0];

  // Temporaries of the temperature and pressure steps
  logic [16:0]        ut_diff;
  logic [15:0]        mc_abs;
  logic [31:0]        x1_t, dv_t, dv_x, quot_s, b5;
  logic signed [31:0] t_w, ps;
  logic [32:0]        r_sh, r_diff;
  logic [31:0]        x3_w, b3_pre, pr_fin;

  always_comb begin
    ut_diff = {1'b0, raw_q[15:0]} - {1'b0, ac6};
    mc_abs  = mc[15] ? 16'(~mc + 16'd1) : mc;
    x1_t    = {{7{acc_q[39]}}, acc_q[39:15]};
    dv_t    = x1_t + mdx;
    dv_x    = xa_q + mdx;
    quot_s  = neg_q ? 32'(~dvd_q + 32'd1) : dvd_q;
    b5      = xa_q + quot_s;
    t_w     = $signed(b5 + 32'd8) >>> 4;
    r_sh    = {rem_q, dvd_q[31]};
    r_diff  = r_sh - {1'b0, dvs_q};
    x3_w    = xa_q + asr32(prod, 5'd11);
    b3_pre  = ((ac1 << 2) + x3_w) << oss_q;
    pr_fin  = p_q + asr32(xa_q + asr32(prod, 5'd16) + bsc_pkg::P_COEF_C, 5'd4);
    ps      = $signed(pr_fin);
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    raw_d   = raw_q;
    tt_d    = tt_q;
    sq_d    = sq_q;
    xa_d    = xa_q;
    b3_d    = b3_q;
    b4_d    = b4_q;
    b7_d    = b7_q;
    p_d     = p_q;
    acc_d   = acc_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    fk_d    = fk_q;
    ft_d    = ft_q;
    fp_d    = fp_q;
    fs_d    = fs_q;
    ov_d    = ov_q && !out_ready_i;
    ok_d    = ok_q;
    ot_d    = ot_q;
    op_pa_d = op_pa_q;
    os_d    = os_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          raw_d   = raw_sample_i;
          step_d  = operation_i ? ST_P_SQ : ST_T_MUL;
          state_d = S_SETUP;
        end
      end

      S_SETUP: begin
        acc_d   = '0;
        cnt_d   = '0;
        rem_d   = '0;
        state_d = S_MUL;
        case (step_q)
          ST_T_MUL: begin
            ma_d = {{23{ut_diff[16]}}, ut_diff};
            mb_d = {16'd0, ac5};
          end
          ST_T_DIV: begin
            dvd_d   = {5'd0, mc_abs, 11'd0};
            dvs_d   = dv_x[31] ? 32'(~dv_x + 32'd1) : dv_x;
            neg_d   = mc[15] ^ dv_x[31];
            state_d = S_DIV;
          end
          ST_P_SQ: begin
            ma_d = sx40(b6);
            mb_d = b6;
          end
          ST_P_X1: begin
            ma_d = sx40(b2);
            mb_d = sq_q;
          end
          ST_P_X2: begin
            ma_d = sx40(ac2);
            mb_d = b6;
          end
          ST_P_X3: begin
            ma_d = sx40(ac3);
            mb_d = b6;
          end
          ST_P_X4: begin
            ma_d = sx40(b1);
            mb_d = sq_q;
          end
          ST_P_B4: begin
            ma_d = sx40(ac4);
            mb_d = xa_q + bsc_pkg::B4_BIAS;
          end
          ST_P_B7: begin
            ma_d = sx40({13'd0, raw_q} - b3_q);
            mb_d = bsc_pkg::B7_SCALE >> oss_q;
          end
          ST_P_DIV: begin
            // A large B7 is divided first and doubled after, as the scheme does.
            dvd_d   = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
            dvs_d   = b4_q;
            state_d = S_DIV;
          end
          ST_P_SQ2: begin
            ma_d = sx40(asr32(p_q, 5'd8));
            mb_d = asr32(p_q, 5'd8);
          end
          ST_P_K1: begin
            ma_d = sx40(xa_q);
            mb_d = bsc_pkg::P_COEF_A;
          end
          ST_P_K2: begin
            ma_d = sx40(bsc_pkg::P_COEF_B);
            mb_d = p_q;
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_MUL: begin
        if (mb_q[0]) begin
          acc_d = acc_q + ma_q;
        end
        ma_d  = {ma_q[38:0], 1'b0};
        mb_d  = {1'b0, mb_q[31:1]};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = S_POST;
        end
      end

      S_DIV: begin
        if (!r_diff[32]) begin
          rem_d = r_diff[31:0];
          dvd_d = {dvd_q[30:0], 1'b1};
        end else begin
          rem_d = r_sh[31:0];
          dvd_d = {dvd_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = S_POST;
        end
      end

      S_POST: begin
        step_d  = step_q + 4'd1;
        state_d = S_SETUP;
        fk_d    = op_q;
        ft_d    = '0;
        fp_d    = '0;
        fs_d    = bsc_pkg::STATUS_OK;
        case (step_q)
          ST_T_MUL: begin
            xa_d = x1_t;
            if (dv_t == 32'd0) begin
              fs_d    = bsc_pkg::STATUS_DIV_ZERO;
              state_d = S_DONE;
            end
          end
          ST_T_DIV: begin
            tt_d    = b5;
            state_d = S_DONE;
            if (t_w > bsc_pkg::TEMP_MAX) begin
              ft_d = 16'(bsc_pkg::TEMP_MAX);
              fs_d = bsc_pkg::STATUS_SAT;
            end else if (t_w < bsc_pkg::TEMP_MIN) begin
              ft_d = 16'(bsc_pkg::TEMP_MIN);
              fs_d = bsc_pkg::STATUS_SAT;
            end else begin
              ft_d = t_w[15:0];
            end
          end
          ST_P_SQ: sq_d = asr32(prod, 5'd12);
          ST_P_X1: xa_d = asr32(prod, 5'd11);
          ST_P_X2: b3_d = asr32(b3_pre + 32'd2, 5'd2);
          ST_P_X3: xa_d = asr32(prod, 5'd13);
          ST_P_X4: xa_d = asr32(xa_q + asr32(prod, 5'd16) + 32'd2, 5'd2);
          ST_P_B4: b4_d = prod >> 15;
          ST_P_B7: begin
            b7_d = prod;
            if (b4_q == 32'd0) begin
              fs_d    = bsc_pkg::STATUS_DIV_ZERO;
              state_d = S_DONE;
            end
          end
          ST_P_DIV: p_d = b7_q[31] ? {dvd_q[30:0], 1'b0} : dvd_q;
          ST_P_SQ2: xa_d = prod;
          ST_P_K1: xa_d = asr32(prod, 5'd16);
          ST_P_K2: begin
            state_d = S_DONE;
            if (ps < 0) begin
              fs_d = bsc_pkg::STATUS_SAT;
            end else if (ps > bsc_pkg::PRES_MAX) begin
              fp_d = 18'(bsc_pkg::PRES_MAX);
              fs_d = bsc_pkg::STATUS_SAT;
            end else begin
              fp_d = pr_fin[17:0];
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ok_d    = fk_q;
          ot_d    = ft_q;
          op_pa_d = fp_q;
          os_d    = fs_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ov_q      <= 1'b0;
      tt_q      <= '0;
      cal_a12_q <= bsc_pkg::CAL_RESET;
      cal_a34_q <= bsc_pkg::CAL_RESET;
      cal_a56_q <= bsc_pkg::CAL_RESET;
      cal_b12_q <= bsc_pkg::CAL_RESET;
      cal_mcd_q <= bsc_pkg::CAL_RESET;
      oss_q     <= bsc_pkg::OSS_RESET;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      tt_q    <= tt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          bsc_pkg::CFG_AC1_AC2:      cal_a12_q <= cfg_data_i;
          bsc_pkg::CFG_AC3_AC4:      cal_a34_q <= cfg_data_i;
          bsc_pkg::CFG_AC5_AC6:      cal_a56_q <= cfg_data_i;
          bsc_pkg::CFG_B1_B2:        cal_b12_q <= cfg_data_i;
          bsc_pkg::CFG_MC_MD:        cal_mcd_q <= cfg_data_i;
          bsc_pkg::CFG_OVERSAMPLING: oss_q     <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    cnt_q   <= cnt_d;
    op_q    <= op_d;
    raw_q   <= raw_d;
    sq_q    <= sq_d;
    xa_q    <= xa_d;
    b3_q    <= b3_d;
    b4_q    <= b4_d;
    b7_q    <= b7_d;
    p_q     <= p_d;
    acc_q   <= acc_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    neg_q   <= neg_d;
    fk_q    <= fk_d;
    ft_q    <= ft_d;
    fp_q    <= fp_d;
    fs_q    <= fs_d;
    ok_q    <= ok_d;
    ot_q    <= ot_d;
    op_pa_q <= op_pa_d;
    os_q    <= os_d;
  end

  assign in_ready_o           = (state_q == S_IDLE);
  assign out_valid_o          = ov_q;
  assign result_kind_o        = ok_q;
  assign temperature_tenths_o = ot_q;
  assign pressure_pa_o        = op_pa_q;
  assign status_o             = os_q;

endmodule

`default_nettype wire

>>> hdl/bsc_checker.sv
// ----------------------------------------------------------------------------
// Barometric compensation checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        result_kind_o,
  input wire logic [15:0] temperature_tenths_o,
  input wire logic [17:0] pressure_pa_o,
  input wire logic [1:0]  status_o
);

  // A stalled transaction keeps its valid.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(pressure_pa_o)
      && $stable(temperature_tenths_o) && $stable(result_kind_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == bsc_pkg::STATUS_OK || status_o == bsc_pkg::STATUS_DIV_ZERO
      || status_o == bsc_pkg::STATUS_SAT)
    else $error("undefined status code");

  // Each result carries only the field of its own kind.
  a_temp_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == bsc_pkg::KIND_TEMP |-> pressure_pa_o == 18'd0)
    else $error("temperature result with nonzero pressure");

  a_pres_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == bsc_pkg::KIND_PRES |-> temperature_tenths_o == 16'd0)
    else $error("pressure result with nonzero temperature");

endmodule

bind barometric_sensor_compensation_top bsc_checker u_bsc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .result_kind_o        (result_kind_o),
  .temperature_tenths_o (temperature_tenths_o),
  .pressure_pa_o        (pressure_pa_o),
  .status_o             (status_o)
);

`default_nettype wire
